// File: rtl/core/command_successor_predictor_top_assert.svh
// Assertion macros for the command successor predictor.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef COMMAND_SUCCESSOR_PREDICTOR_TOP_ASSERT_SVH
`define COMMAND_SUCCESSOR_PREDICTOR_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CSP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An implication that is checked in the same cycle.
`define CSP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/csp_pkg.sv
`timescale 1ns / 1ps
package csp_pkg;

	localparam int unsigned ENTRIES_DEF    = 32;
	localparam int unsigned COUNT_BITS_DEF = 16;

	// Depth of the command queue between the front and the back.
	localparam int unsigned QDEPTH = 2;

	// Confidence is count * CONF_SCALE / (total + CONF_BIAS), clamped.
	localparam int unsigned CONF_SCALE = 100;
	localparam logic [6:0]  CONF_MAX   = 7'd95;
	localparam logic [6:0]  CONF_MIN   = 7'd30;
	localparam logic [32:0] CONF_BIAS  = 33'd5;

	// Width of the divisor: the 32-bit total plus the bias.
	localparam int unsigned DEN_W = 33;

	typedef enum logic [1:0] {
		OP_LEARN   = 2'd0,
		OP_PREDICT = 2'd1,
		OP_COUNT   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DIV
	} bk_state_t;

	typedef struct packed {
		op_t         op;
		logic        key_zero;
		logic [31:0] prev_key;
		logic [31:0] next_key;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [31:0] predicted_key;
		logic [15:0] hit_count;
		logic [6:0]  confidence;
		logic        dropped;
	} res_t;

endpackage

// File: rtl/core/csp_front.sv
`timescale 1ns / 1ps
module csp_front
	import csp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] prev_key,
	input  logic [31:0] next_key,
	input  logic        pop,
	output logic        cmd_vld,
	output cmd_t        cmd
);

	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned FW = $clog2(QDEPTH + 1);

	cmd_t          queue_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [FW-1:0] fill_q;
	logic          push;
	cmd_t          cmd_in;

	// Classify the word on entry so the back only looks at a flag for the empty key.
	always_comb begin
		cmd_in.op       = op_t'(op);
		cmd_in.key_zero = (prev_key == 32'd0);
		cmd_in.prev_key = prev_key;
		cmd_in.next_key = next_key;
	end

	assign busy    = (fill_q == FW'(QDEPTH));
	assign push    = start && !busy;
	assign cmd_vld = (fill_q != '0);
	assign cmd     = queue_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cmd_in;
		end
	end

endmodule

// File: rtl/core/csp_div.sv
`timescale 1ns / 1ps
module csp_div
	import csp_pkg::*;
#(
	parameter int unsigned NW = 23,
	parameter int unsigned DW = DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] acc_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// Restoring division, one quotient bit per cycle; quotient bits shift into acc_q.
	always_comb begin
		trial = {rem_q, acc_q[NW-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = ge ? (trial - {1'b0, den_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			acc_q <= {acc_q[NW-2:0], ge};
			rem_q <= diff[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = acc_q;

endmodule

// File: rtl/core/csp_back.sv
`timescale 1ns / 1ps
module csp_back
	import csp_pkg::*;
#(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_vld,
	input  cmd_t cmd,
	output logic pop,
	output logic done,
	output res_t res
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned CB = COUNT_BITS;
	localparam int unsigned EW = 64 + CB;
	localparam int unsigned NW = CB + 7;

	logic [EW-1:0] mem [ENTRIES];

	bk_state_t     state_q, state_d;
	cmd_t          cmd_q;
	logic [CW-1:0] entry_count_q, entry_count_d;
	logic [31:0]   total_q, total_d;
	logic [CW-1:0] issue_q;
	logic          rd_vld_s1;
	logic [IW-1:0] ridx_s1;
	logic [EW-1:0] ent_s1;
	logic [CB-1:0] best_cnt_q;
	logic [31:0]   best_succ_q;
	logic          hit_q;
	logic          done_q;
	res_t          res_q;

	logic          issue;
	logic          emit;
	res_t          res_d;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          div_go;
	logic          div_done;
	logic [NW-1:0] div_quo;
	logic [NW-1:0] div_num;
	logic [DEN_W-1:0] div_den;

	logic [31:0]   e_prev;
	logic [31:0]   e_succ;
	logic [CB-1:0] e_cnt;
	logic          prev_hit;
	logic          pair_hit;
	logic          best_upd;

	assign e_prev   = ent_s1[EW-1 -: 32];
	assign e_succ   = ent_s1[CB+31 -: 32];
	assign e_cnt    = ent_s1[CB-1:0];
	assign prev_hit = (e_prev == cmd_q.prev_key);
	assign pair_hit = prev_hit && (e_succ == cmd_q.next_key);
	assign best_upd = (state_q == BK_SCAN) && rd_vld_s1 && (cmd_q.op == OP_PREDICT)
		&& prev_hit && (e_cnt > best_cnt_q);

	assign div_num = NW'(best_cnt_q) * NW'(CONF_SCALE);
	assign div_den = DEN_W'(total_q) + CONF_BIAS;

	csp_div #(
		.NW(NW),
		.DW(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		state_d       = state_q;
		entry_count_d = entry_count_q;
		total_d       = total_q;
		pop           = 1'b0;
		issue         = 1'b0;
		emit          = 1'b0;
		res_d         = '0;
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = '0;
		div_go        = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_vld) begin
					pop = 1'b1;
					case (cmd.op)
						OP_COUNT: begin
							emit = 1'b1;
							if (total_q != 32'hFFFF_FFFF) begin
								total_d = total_q + 32'd1;
							end
						end
						OP_CLEAR: begin
							emit          = 1'b1;
							entry_count_d = '0;
						end
						OP_LEARN, OP_PREDICT: begin
							if (cmd.key_zero) begin
								emit = 1'b1;
							end else begin
								state_d = BK_SCAN;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			BK_SCAN: begin
				issue = (issue_q < entry_count_q);
				if (rd_vld_s1 && (cmd_q.op == OP_LEARN) && pair_hit) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_s1;
					mem_wdata = {e_prev, e_succ, (e_cnt == '1) ? e_cnt : e_cnt + 1'b1};
					emit      = 1'b1;
					state_d   = BK_IDLE;
				end else if (!rd_vld_s1 && !issue) begin
					if (cmd_q.op == OP_LEARN) begin
						emit    = 1'b1;
						state_d = BK_IDLE;
						if (entry_count_q < CW'(ENTRIES)) begin
							mem_we        = 1'b1;
							mem_waddr     = entry_count_q[IW-1:0];
							mem_wdata     = {cmd_q.prev_key, cmd_q.next_key, CB'(1)};
							entry_count_d = entry_count_q + 1'b1;
						end else begin
							res_d.dropped = 1'b1;
						end
					end else if (hit_q) begin
						div_go  = 1'b1;
						state_d = BK_DIV;
					end else begin
						emit    = 1'b1;
						state_d = BK_IDLE;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					emit                = 1'b1;
					state_d             = BK_IDLE;
					res_d.found         = 1'b1;
					res_d.predicted_key = best_succ_q;
					res_d.hit_count     = 16'(best_cnt_q);
					if (div_quo > NW'(CONF_MAX)) begin
						res_d.confidence = CONF_MAX;
					end else if (div_quo < NW'(CONF_MIN)) begin
						res_d.confidence = CONF_MIN;
					end else begin
						res_d.confidence = div_quo[6:0];
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			entry_count_q <= '0;
			total_q       <= '0;
			issue_q       <= '0;
			rd_vld_s1     <= 1'b0;
			hit_q         <= 1'b0;
			done_q        <= 1'b0;
			res_q         <= '0;
		end else begin
			state_q       <= state_d;
			entry_count_q <= entry_count_d;
			total_q       <= total_d;
			rd_vld_s1     <= issue;
			done_q        <= emit;
			res_q         <= emit ? res_d : '0;
			if (pop) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else begin
				if (issue) begin
					issue_q <= issue_q + 1'b1;
				end
				if (best_upd) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q      <= cmd;
			best_cnt_q <= '0;
		end else if (best_upd) begin
			best_cnt_q  <= e_cnt;
			best_succ_q <= e_succ;
		end
		if (issue) begin
			ridx_s1 <= issue_q[IW-1:0];
		end
	end

	// Table memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			ent_s1 <= mem[issue_q[IW-1:0]];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: rtl/core/command_successor_predictor_top.sv
`timescale 1ns / 1ps
// Channel   Handshake               Word
// command   start / busy            op, prev_key, next_key
// result    done (one-cycle strobe) found, predicted_key, hit_count, confidence, dropped
//
// Count and clear are answered straight from idle in the back end, as is an empty previous key.
// Learn and predict scan the table one entry per cycle through the table memory read port;
// a learn stops early at its matching pair, and a predict that hits then runs the serial
// divider; the back end takes no new word until the current one is answered.
// Reset clears the entry count and the command total; the table needs no clearing pass.
// busy rises when the two-word command queue is full; the result side cannot stall.
module command_successor_predictor_top
	import csp_pkg::*;
#(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] prev_key,
	input  logic [31:0] next_key,
	output logic        done,
	output logic        found,
	output logic [31:0] predicted_key,
	output logic [15:0] hit_count,
	output logic [6:0]  confidence,
	output logic        dropped
);

	cmd_t cmd;
	logic cmd_vld;
	logic pop;
	res_t res;
	logic conf_ok;
	logic miss_zero;

	// The front end takes command words and classifies them into the queue.
	csp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.op      (op),
		.prev_key(prev_key),
		.next_key(next_key),
		.pop     (pop),
		.cmd_vld (cmd_vld),
		.cmd     (cmd)
	);

	// The back end owns the transition table, the command total and the divider.
	csp_back #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_vld(cmd_vld),
		.cmd    (cmd),
		.pop    (pop),
		.done   (done),
		.res    (res)
	);

	assign found         = res.found;
	assign predicted_key = res.predicted_key;
	assign hit_count     = res.hit_count;
	assign confidence    = res.confidence;
	assign dropped       = res.dropped;

	// Checks on the result word, evaluated beside the assertions below.
	assign conf_ok   = (confidence >= CONF_MIN) && (confidence <= CONF_MAX);
	assign miss_zero = (predicted_key == 32'd0) && (hit_count == 16'd0) && (confidence == 7'd0);

	`include "command_successor_predictor_top_assert.svh"

	// Result fields are cleared between strobes, so a hit or a drop shows only with done.
	`CSP_ASSERT_ALWAYS(a_found_strobed, !found || done, "found without done")
	`CSP_ASSERT_ALWAYS(a_drop_alone, !dropped || (done && !found), "dropped out of place")
	// A hit carries a clamped confidence; a miss carries a zero key, count and confidence.
	`CSP_ASSERT_IMPL(a_conf_clamp, done && found, conf_ok, "confidence out of range")
	`CSP_ASSERT_IMPL(a_miss_zero, done && !found, miss_zero, "miss carries data")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the command successor predictor.
// A driver feeds command words through the start/busy handshake and runs each
// accepted word through a local model of the transition table, which queues
// the result word that the block must return. A monitor pops that queue on
// every done strobe and compares the result word field by field.
module tb;
	import csp_pkg::*;

	localparam int unsigned TABLE_DEPTH  = ENTRIES_DEF;
	localparam int          RANDOM_WORDS = 840;
	localparam int          DRAIN_LIMIT  = 20000;
	localparam int          REPORT_LIMIT = 50;

	localparam res_t NO_RESULT = '0;

	// One row of the directed part. When typed is set, want is the result word
	// to expect; otherwise the local model supplies it.
	typedef struct packed {
		op_t         cmd_op;
		logic [31:0] prev;
		logic [31:0] succ;
		logic        typed;
		res_t        want;
	} cmd_row_t;

	localparam cmd_row_t DIRECTED_WORDS [22] = '{
		// Fresh table: nothing to predict.
		'{OP_PREDICT, 32'd5,          32'd0,          1'b1, NO_RESULT},
		// An empty previous command is never learned and never predicted.
		'{OP_LEARN,   32'd0,          32'd7,          1'b1, NO_RESULT},
		'{OP_PREDICT, 32'd0,          32'd0,          1'b1, NO_RESULT},
		// Same pair five times with a zero total: 500/5 clamps to the top.
		'{OP_LEARN,   32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_LEARN,   32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_LEARN,   32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_LEARN,   32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_LEARN,   32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_PREDICT, 32'hFFFF_FFFF,  32'h0000_0000,  1'b1,
			'{1'b1, 32'h0000_0000, 16'd5, CONF_MAX, 1'b0}},
		'{OP_LEARN,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, NO_RESULT},
		'{OP_PREDICT, 32'hFFFF_FFFF,  32'h0000_0000,  1'b0, NO_RESULT},
		'{OP_COUNT,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, NO_RESULT},
		'{OP_COUNT,   32'h0000_0000,  32'h0000_0000,  1'b1, NO_RESULT},
		'{OP_COUNT,   32'h0000_0001,  32'h0000_0001,  1'b1, NO_RESULT},
		// Clear drops the pairs but keeps the command total.
		'{OP_CLEAR,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, NO_RESULT},
		'{OP_PREDICT, 32'hFFFF_FFFF,  32'h0000_0000,  1'b1, NO_RESULT},
		// Two successors tie at one; the first entry wins, 100/8 clamps up.
		'{OP_LEARN,   32'h0000_0001,  32'h8000_0000,  1'b1, NO_RESULT},
		'{OP_LEARN,   32'h0000_0001,  32'h0000_0001,  1'b1, NO_RESULT},
		'{OP_PREDICT, 32'h0000_0001,  32'h0000_0000,  1'b1,
			'{1'b1, 32'h8000_0000, 16'd1, CONF_MIN, 1'b0}},
		'{OP_LEARN,   32'h0000_0001,  32'h0000_0001,  1'b1, NO_RESULT},
		'{OP_PREDICT, 32'h0000_0001,  32'h0000_0000,  1'b0, NO_RESULT},
		// A key that is present nowhere in the table.
		'{OP_PREDICT, 32'hFFFF_FFFE,  32'h0000_0000,  1'b1, NO_RESULT}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        start    = 1'b0;
	logic [1:0]  op       = OP_COUNT;
	logic [31:0] prev_key = '0;
	logic [31:0] next_key = '0;
	logic        busy;
	logic        done;
	logic        found;
	logic [31:0] predicted_key;
	logic [15:0] hit_count;
	logic [6:0]  confidence;
	logic        dropped;

	// Local copy of the transition table and the command total.
	logic [31:0] prev_tab [TABLE_DEPTH];
	logic [31:0] succ_tab [TABLE_DEPTH];
	logic [15:0] hits_tab [TABLE_DEPTH];
	int unsigned used_entries = 0;
	logic [31:0] seen_commands = '0;

	// Result words still owed by the block, oldest first.
	res_t expected_words [$];
	res_t oldest;
	int   mismatches = 0;

	command_successor_predictor_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.prev_key      (prev_key),
		.next_key      (next_key),
		.done          (done),
		.found         (found),
		.predicted_key (predicted_key),
		.hit_count     (hit_count),
		.confidence    (confidence),
		.dropped       (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or stops answering.
	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Applies one command word to the local table and returns the result word
	// it must produce. Counts saturate at all ones, and so does the total.
	function automatic res_t successor_result(op_t cmd_op, logic [31:0] pk, logic [31:0] nk);
		res_t        r;
		logic        matched;
		logic [15:0] best;
		int unsigned best_at;
		logic [63:0] pct;
		r        = NO_RESULT;
		matched  = 1'b0;
		best     = '0;
		best_at  = 0;
		case (cmd_op)
			OP_LEARN: begin
				if (pk != '0) begin
					for (int unsigned i = 0; i < used_entries; i++) begin
						if (!matched && prev_tab[i] == pk && succ_tab[i] == nk) begin
							matched = 1'b1;
							if (hits_tab[i] != '1)
								hits_tab[i] = hits_tab[i] + 16'd1;
						end
					end
					if (!matched) begin
						if (used_entries < TABLE_DEPTH) begin
							prev_tab[used_entries] = pk;
							succ_tab[used_entries] = nk;
							hits_tab[used_entries] = 16'd1;
							used_entries++;
						end else begin
							r.dropped = 1'b1;
						end
					end
				end
			end
			OP_PREDICT: begin
				if (pk != '0) begin
					// Strictly greater keeps the first entry on a tie.
					for (int unsigned i = 0; i < used_entries; i++) begin
						if (prev_tab[i] == pk && hits_tab[i] > best) begin
							best    = hits_tab[i];
							best_at = i;
						end
					end
					if (best != '0) begin
						pct = (64'(best) * 64'(CONF_SCALE)) /
							(64'(seen_commands) + 64'(CONF_BIAS));
						if (pct > 64'(CONF_MAX))
							pct = 64'(CONF_MAX);
						if (pct < 64'(CONF_MIN))
							pct = 64'(CONF_MIN);
						r.found         = 1'b1;
						r.predicted_key = succ_tab[best_at];
						r.hit_count     = best;
						r.confidence    = pct[6:0];
					end
				end
			end
			OP_COUNT: begin
				if (seen_commands != '1)
					seen_commands = seen_commands + 32'd1;
			end
			default: begin
				used_entries = 0;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Holds a command word on the ports until the block takes it, then queues
	// the result word it owes. start stays high on return, so a following word
	// can go out on the very next edge.
	task automatic send_word(op_t cmd_op, logic [31:0] pk, logic [31:0] nk,
			logic typed, res_t want);
		res_t model;
		start    <= 1'b1;
		op       <= cmd_op;
		prev_key <= pk;
		next_key <= nk;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model = successor_result(cmd_op, pk, nk);
		expected_words.push_back(typed ? want : model);
	endtask

	// Random pause after some words: mostly short, sometimes long enough
	// to let a full scan and divide finish.
	task automatic idle_gap();
		if ($urandom_range(99) < 31) begin
			start <= 1'b0;
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(90, 5)) @(posedge clk);
			else
				repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Every done strobe must match the oldest owed result word.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: stray result, expected nothing, actual %0h %0h %0h %0h %0h",
					$time, found, predicted_key, hit_count, confidence, dropped);
				mismatches++;
			end else begin
				oldest = expected_words.pop_front();
				check_field("found", oldest.found, found);
				check_field("predicted_key", oldest.predicted_key, predicted_key);
				check_field("hit_count", oldest.hit_count, hit_count);
				check_field("confidence", oldest.confidence, confidence);
				check_field("dropped", oldest.dropped, dropped);
			end
		end
	end

	initial begin
		logic [31:0] prev_pool [8];
		logic [31:0] succ_pool [8];
		int          prev_n;
		int          succ_n;
		int          pick;
		int          drain;
		logic [31:0] first_succ;
		logic [31:0] pk;
		logic [31:0] nk;
		op_t         cmd_op;
		prev_n = 1;
		succ_n = 1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_WORDS[r]) begin
			send_word(DIRECTED_WORDS[r].cmd_op, DIRECTED_WORDS[r].prev,
				DIRECTED_WORDS[r].succ, DIRECTED_WORDS[r].typed, DIRECTED_WORDS[r].want);
			idle_gap();
		end

		// Fill the table to the brim: the next new pair is dropped, while a
		// pair that is already present still counts up.
		send_word(OP_CLEAR, $urandom(), $urandom(), 1'b0, NO_RESULT);
		first_succ = $urandom();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_word(OP_LEARN, 32'(i + 2), (i == 0) ? first_succ : $urandom(), 1'b0, NO_RESULT);
			idle_gap();
		end
		send_word(OP_LEARN, 32'd40, 32'd40, 1'b0, NO_RESULT);
		send_word(OP_LEARN, 32'd2, first_succ, 1'b0, NO_RESULT);
		send_word(OP_PREDICT, 32'd2, 32'd0, 1'b0, NO_RESULT);
		send_word(OP_PREDICT, 32'd40, 32'd0, 1'b0, NO_RESULT);
		idle_gap();

		// Random words drawn mostly from small key pools so that pairs repeat,
		// predictions hit and the table fills up; a tenth are arbitrary keys.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0) begin
				prev_n = $urandom_range(8, 1);
				succ_n = $urandom_range(8, 1);
				for (int k = 0; k < 8; k++) begin
					prev_pool[k] = ($urandom_range(3) == 0) ? 32'($urandom_range(15)) : $urandom();
					succ_pool[k] = ($urandom_range(3) == 0) ? 32'($urandom_range(15)) : $urandom();
				end
			end
			pick = $urandom_range(99);
			cmd_op = (pick < 48) ? OP_LEARN : (pick < 78) ? OP_PREDICT :
				(pick < 98) ? OP_COUNT : OP_CLEAR;
			pk = ($urandom_range(9) == 0) ? $urandom() : prev_pool[$urandom_range(prev_n - 1)];
			nk = ($urandom_range(9) == 0) ? $urandom() : succ_pool[$urandom_range(succ_n - 1)];
			send_word(cmd_op, pk, nk, 1'b0, NO_RESULT);
			// A long run in the middle goes without any pause at all.
			if (n < 300 || n >= 500)
				idle_gap();
		end
		start <= 1'b0;

		drain = 0;
		while (expected_words.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		// Extra cycles to catch any stray result word after the last one.
		repeat (100) @(posedge clk);
		if (expected_words.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, expected_words.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: command_successor_predictor_top.f
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/csp_front.sv
rtl/core/csp_div.sv
rtl/core/csp_back.sv
rtl/core/command_successor_predictor_top.sv
tb/tb.sv
